FILE: src/magnetometer_sample_compensation_core_assert.svh
// Assertion macros shared by the magnetometer compensation RTL.
// Include with the bare file name; no other dependencies.
`ifndef MAGNETOMETER_SAMPLE_COMPENSATION_CORE_ASSERT_SVH
`define MAGNETOMETER_SAMPLE_COMPENSATION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
`define MSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define MSC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MSC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: src/msc_pkg.sv
// Shared types and constants for the magnetometer compensation core.
// No dependencies.
package msc_pkg;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StOverflow = 2'd1,
    StDivZero  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CfgXyTrims   = 3'd0,
    CfgHallZ1    = 3'd1,
    CfgZTrims    = 3'd2,
    CfgUserOffs  = 3'd3,
    CfgUserScale = 3'd4,
    CfgUserCalEn = 3'd5
  } cfg_idx_e;

  // Control that travels alongside each transaction
  typedef struct packed {
    logic    valid;
    status_e status;
  } ctrl_t;

  localparam int unsigned QuoBits     = 18;  // quotient bits, clamps far beyond 16 bits
  localparam int unsigned FrontStages = 6;
  localparam int unsigned XyNumW      = 64;
  localparam int unsigned ZNumW       = 50;
  localparam logic [47:0] UserScalesReset = 48'h4000_4000_4000;

endpackage

FILE: src/msc_div.sv
// Pipelined restoring divider, one quotient bit per stage, clamped magnitude.
// Depends on nothing; numerator arrives already biased for round-to-nearest.
module msc_div #(
  parameter int unsigned W  = 64,
  parameter int unsigned QB = 18
) (
  input  logic                 clk_i,
  input  logic [W-1:0]         num_i,
  input  logic [W-1:0]         den_i,
  input  logic                 neg_i,
  output logic signed [QB:0]   quo_o
);

  localparam int unsigned EW = W + QB;

  logic [W-1:0]  rem_q [QB];
  logic [W-1:0]  den_q [QB];
  logic [QB-1:0] q_q   [QB+1];
  logic          ovf_q [QB+1];
  logic          neg_q [QB+1];
  logic [QB-1:0] qmag;

  // Entry stage: detect quotients too large for QB bits
  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    den_q[0] <= den_i;
    ovf_q[0] <= EW'(num_i) >= (EW'(den_i) << QB);
    neg_q[0] <= neg_i;
    q_q[0]   <= '0;
  end

  // One quotient bit per stage, MSB first
  for (genvar j = 1; j <= QB; j++) begin : g_stage
    localparam int unsigned B = QB - j;
    logic [EW-1:0] trial;
    logic          fit;

    assign trial = EW'(den_q[j-1]) << B;
    assign fit   = EW'(rem_q[j-1]) >= trial;

    always_ff @(posedge clk_i) begin
      q_q[j]   <= q_q[j-1] | (fit ? (QB'(1) << B) : '0);
      ovf_q[j] <= ovf_q[j-1];
      neg_q[j] <= neg_q[j-1];
    end

    if (j < QB) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[j] <= fit ? W'(EW'(rem_q[j-1]) - trial) : rem_q[j-1];
        den_q[j] <= den_q[j-1];
      end
    end
  end

  assign qmag  = ovf_q[QB] ? '1 : q_q[QB];
  assign quo_o = neg_q[QB] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

endmodule

FILE: src/msc_front.sv
// Front end: unpacks a frame and forms trim numerators and divisors.
// Depends on msc_pkg; six register stages, products split to 32-bit class.
module msc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [15:0]                  x_word_i,
  input  logic [15:0]                  y_word_i,
  input  logic [15:0]                  z_word_i,
  input  logic [15:0]                  hall_word_i,
  input  logic [47:0]                  xy_trims_i,
  input  logic [31:0]                  hall_z1_trims_i,
  input  logic [47:0]                  z_trims_i,
  output msc_pkg::ctrl_t               ctrl_o,
  output logic [msc_pkg::XyNumW-1:0]   num_x_o,
  output logic [msc_pkg::XyNumW-1:0]   num_y_o,
  output logic [msc_pkg::XyNumW-1:0]   den_xy_o,
  output logic                         neg_x_o,
  output logic                         neg_y_o,
  output logic [msc_pkg::ZNumW-1:0]    num_z_o,
  output logic [msc_pkg::ZNumW-1:0]    den_z_o,
  output logic                         neg_z_o
);
  import msc_pkg::*;

  logic signed [12:0] rx, ry;
  logic signed [14:0] rz;
  logic [13:0]        h;
  logic signed [7:0]  x2, y2, xy2;
  logic [7:0]         xy1;
  logic [15:0]        z1, xyz1;
  logic signed [15:0] z2, z3, z4;
  logic signed [17:0] e, ne;
  logic signed [9:0]  gx, gy;

  ctrl_t ctrl1_d, ctrl3_d;
  ctrl_t ctrl1_q, ctrl2_q, ctrl3_q, ctrl4_q, ctrl5_q, ctrl6_q;

  // stage 1
  logic signed [35:0] ee1_q;
  logic signed [32:0] eh1_q;
  logic [27:0]        hh1_q;
  logic signed [22:0] mx1_q, my1_q;
  logic signed [16:0] dz1_q;
  logic signed [33:0] zp1_q;
  logic [29:0]        z1h1_q;
  // stage 2
  logic signed [43:0] a1_2_q;
  logic signed [41:0] a2_2_q;
  logic [27:0]        hh2_q;
  logic signed [22:0] mx2_q, my2_q;
  logic signed [35:0] n2_q;
  logic signed [32:0] d2_q;
  // stage 3
  logic signed [44:0] a3_q;
  logic [40:0]        den3_q;
  logic signed [22:0] mx3_q, my3_q;
  logic signed [35:0] n3_q;
  logic signed [32:0] d3_q;
  // stage 4
  logic signed [45:0] pxl4_q, pyl4_q;
  logic signed [46:0] pxh4_q, pyh4_q;
  logic [40:0]        den4_q;
  logic signed [35:0] n4_q;
  logic signed [32:0] d4_q;
  // stage 5
  logic signed [63:0] nx5_q, ny5_q;
  logic [40:0]        den5_q;
  logic signed [35:0] n5_q;
  logic signed [32:0] d5_q;
  // stage 6 magnitudes
  logic [63:0]        abs_x, abs_y;
  logic [35:0]        abs_n;
  logic [32:0]        abs_d;

  // Field unpacking
  assign rx   = $signed(x_word_i[15:3]);
  assign ry   = $signed(y_word_i[15:3]);
  assign rz   = $signed(z_word_i[15:1]);
  assign h    = hall_word_i[15:2];
  assign x2   = $signed(xy_trims_i[23:16]);
  assign y2   = $signed(xy_trims_i[31:24]);
  assign xy1  = xy_trims_i[39:32];
  assign xy2  = $signed(xy_trims_i[47:40]);
  assign z1   = hall_z1_trims_i[15:0];
  assign xyz1 = hall_z1_trims_i[31:16];
  assign z2   = $signed(z_trims_i[15:0]);
  assign z3   = $signed(z_trims_i[31:16]);
  assign z4   = $signed(z_trims_i[47:32]);

  assign e  = $signed({2'b00, xyz1}) - $signed({4'b0000, h});
  assign ne = -e;
  assign gx = 10'(x2) + 10'sd160;
  assign gy = 10'(y2) + 10'sd160;

  // Status decided up front; overflow wins over zero hall
  always_comb begin
    ctrl1_d.valid = start_i;
    if (hall_word_i[0]) begin
      ctrl1_d.status = StOverflow;
    end else if (h == '0) begin
      ctrl1_d.status = StDivZero;
    end else begin
      ctrl1_d.status = StOk;
    end
  end

  // Zero z divisor caught once the divisor is known at stage 2
  always_comb begin
    ctrl3_d = ctrl2_q;
    if (ctrl2_q.status == StOk && d2_q == '0) begin
      ctrl3_d.status = StDivZero;
    end
  end

  // Control pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
      ctrl3_q <= '0;
      ctrl4_q <= '0;
      ctrl5_q <= '0;
      ctrl6_q <= '0;
    end else begin
      ctrl1_q <= ctrl1_d;
      ctrl2_q <= ctrl1_q;
      ctrl3_q <= ctrl3_d;
      ctrl4_q <= ctrl3_q;
      ctrl5_q <= ctrl4_q;
      ctrl6_q <= ctrl5_q;
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    // stage 1: first-level products
    ee1_q  <= 36'(e) * 36'(e);
    eh1_q  <= 33'(e) * 33'($signed({1'b0, h}));
    hh1_q  <= 28'(h) * 28'(h);
    mx1_q  <= 23'(rx) * 23'(gx);
    my1_q  <= 23'(ry) * 23'(gy);
    dz1_q  <= 17'(rz) - 17'(z4);
    zp1_q  <= 34'(z3) * 34'(ne);
    z1h1_q <= 30'(z1) * 30'(h);
    // stage 2: trim-weighted terms, z numerator and divisor
    a1_2_q <= 44'(xy2) * 44'(ee1_q);
    a2_2_q <= 42'($signed({1'b0, xy1})) * 42'(eh1_q);
    hh2_q  <= hh1_q;
    mx2_q  <= mx1_q;
    my2_q  <= my1_q;
    n2_q   <= (36'(dz1_q) <<< 17) - 36'(zp1_q);
    d2_q   <= (33'(z2) <<< 15) + 33'($signed({1'b0, z1h1_q}));
    // stage 3: sum of the hall polynomial
    a3_q   <= 45'(a1_2_q) + 45'(a2_2_q) + 45'($signed({1'b0, hh2_q, 8'b0}));
    den3_q <= {hh2_q, 13'b0};
    mx3_q  <= mx2_q;
    my3_q  <= my2_q;
    n3_q   <= n2_q;
    d3_q   <= d2_q;
    // stage 4: numerator as two partial products
    pxl4_q <= 46'(mx3_q) * 46'($signed({1'b0, a3_q[20:0]}));
    pxh4_q <= 47'(mx3_q) * 47'($signed(a3_q[44:21]));
    pyl4_q <= 46'(my3_q) * 46'($signed({1'b0, a3_q[20:0]}));
    pyh4_q <= 47'(my3_q) * 47'($signed(a3_q[44:21]));
    den4_q <= den3_q;
    n4_q   <= n3_q;
    d4_q   <= d3_q;
    // stage 5: combine partial products
    nx5_q  <= 64'((68'(pxh4_q) <<< 21) + 68'(pxl4_q));
    ny5_q  <= 64'((68'(pyh4_q) <<< 21) + 68'(pyl4_q));
    den5_q <= den4_q;
    n5_q   <= n4_q;
    d5_q   <= d4_q;
  end

  assign abs_x = nx5_q[63] ? 64'(-nx5_q) : 64'(nx5_q);
  assign abs_y = ny5_q[63] ? 64'(-ny5_q) : 64'(ny5_q);
  assign abs_n = n5_q[35]  ? 36'(-n5_q)  : 36'(n5_q);
  assign abs_d = d5_q[32]  ? 33'(-d5_q)  : 33'(d5_q);

  // stage 6: magnitudes with half-divisor bias for rounding
  always_ff @(posedge clk_i) begin
    num_x_o  <= abs_x + 64'(den5_q >> 1);
    num_y_o  <= abs_y + 64'(den5_q >> 1);
    den_xy_o <= 64'(den5_q);
    neg_x_o  <= nx5_q[63];
    neg_y_o  <= ny5_q[63];
    num_z_o  <= 50'({abs_n, 13'b0}) + 50'(abs_d >> 1);
    den_z_o  <= 50'(abs_d);
    neg_z_o  <= n5_q[35] ^ d5_q[32];
  end

  assign ctrl_o = ctrl6_q;

endmodule

FILE: src/msc_post.sv
// Per-axis back end: trim offset, saturation, optional user calibration.
// Depends on msc_pkg; three register stages, the last one drives the output.
module msc_post (
  input  logic                          clk_i,
  input  logic signed [msc_pkg::QuoBits:0] quo_i,
  input  logic signed [10:0]            add_i,
  input  logic signed [15:0]            off_i,
  input  logic [15:0]                   scale_i,
  input  logic                          cal_en_i,
  input  logic                          ok_i,
  output logic signed [15:0]            field_o
);
  import msc_pkg::*;

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    logic signed [15:0] r;
    if (v > 21'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -21'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  logic signed [15:0] f1_q, f2_q, field_q;
  logic signed [33:0] prod2_q;
  logic [33:0]        mag;
  logic [19:0]        rnd;
  logic signed [20:0] sv;

  // p3 rounding: ties away from zero
  assign mag = prod2_q[33] ? 34'(-prod2_q) : 34'(prod2_q);
  assign rnd = 20'((mag + 34'd8192) >> 14);
  assign sv  = prod2_q[33] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});

  always_ff @(posedge clk_i) begin
    // p1: add trim offset and clamp
    f1_q    <= sat16(21'(quo_i) + 21'(add_i));
    // p2: user offset and scale
    prod2_q <= 34'(17'(f1_q) - 17'(off_i)) * 34'($signed({1'b0, scale_i}));
    f2_q    <= f1_q;
    // p3: select and mask faults
    if (!ok_i) begin
      field_q <= '0;
    end else if (cal_en_i) begin
      field_q <= sat16(sv);
    end else begin
      field_q <= f2_q;
    end
  end

  assign field_o = field_q;

endmodule

FILE: src/magnetometer_sample_compensation_core.sv
// Top level of the magnetometer sample compensation core.
// Depends on msc_pkg, msc_front, msc_div, msc_post and the assertion header.
//
// Takes one frame per clock: start_i may be high every cycle and busy_o is
// always low. Each transaction returns one result, shown for one cycle with
// done_o, after the 6 front stages, the 19-stage quotient pipeline and 3
// back-end stages; results leave in order and cannot be held off. Configuration
// writes take effect at once and must only happen while no transaction is in
// flight.
`include "magnetometer_sample_compensation_core_assert.svh"

module magnetometer_sample_compensation_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [15:0]        x_word_i,
  input  logic [15:0]        y_word_i,
  input  logic [15:0]        z_word_i,
  input  logic [15:0]        hall_word_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [47:0]        cfg_data_i,
  output logic               done_o,
  output logic signed [15:0] field_x_o,
  output logic signed [15:0] field_y_o,
  output logic signed [15:0] field_z_o,
  output logic [1:0]         status_o
);
  import msc_pkg::*;

  localparam int unsigned DlDepth = QuoBits + 4;
  localparam int unsigned Lat     = FrontStages + QuoBits + 4;

  logic [47:0] xy_trims_q, z_trims_q, user_offsets_q, user_scales_q;
  logic [31:0] hall_z1_trims_q;
  logic        user_cal_en_q;

  ctrl_t              front_ctrl;
  ctrl_t              dl_q [DlDepth];
  logic [XyNumW-1:0]  num_x, num_y, den_xy;
  logic [ZNumW-1:0]   num_z, den_z;
  logic               neg_x, neg_y, neg_z;
  logic signed [QuoBits:0] quo_x, quo_y, quo_z;
  logic               out_ok;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xy_trims_q      <= '0;
      hall_z1_trims_q <= '0;
      z_trims_q       <= '0;
      user_offsets_q  <= '0;
      user_scales_q   <= UserScalesReset;
      user_cal_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgXyTrims:   xy_trims_q      <= cfg_data_i;
        CfgHallZ1:    hall_z1_trims_q <= cfg_data_i[31:0];
        CfgZTrims:    z_trims_q       <= cfg_data_i;
        CfgUserOffs:  user_offsets_q  <= cfg_data_i;
        CfgUserScale: user_scales_q   <= cfg_data_i;
        CfgUserCalEn: user_cal_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  msc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .x_word_i        (x_word_i),
    .y_word_i        (y_word_i),
    .z_word_i        (z_word_i),
    .hall_word_i     (hall_word_i),
    .xy_trims_i      (xy_trims_q),
    .hall_z1_trims_i (hall_z1_trims_q),
    .z_trims_i       (z_trims_q),
    .ctrl_o          (front_ctrl),
    .num_x_o         (num_x),
    .num_y_o         (num_y),
    .den_xy_o        (den_xy),
    .neg_x_o         (neg_x),
    .neg_y_o         (neg_y),
    .num_z_o         (num_z),
    .den_z_o         (den_z),
    .neg_z_o         (neg_z)
  );

  msc_div #(.W(XyNumW), .QB(QuoBits)) u_div_x (
    .clk_i (clk_i), .num_i (num_x), .den_i (den_xy), .neg_i (neg_x), .quo_o (quo_x)
  );

  msc_div #(.W(XyNumW), .QB(QuoBits)) u_div_y (
    .clk_i (clk_i), .num_i (num_y), .den_i (den_xy), .neg_i (neg_y), .quo_o (quo_y)
  );

  msc_div #(.W(ZNumW), .QB(QuoBits)) u_div_z (
    .clk_i (clk_i), .num_i (num_z), .den_i (den_z), .neg_i (neg_z), .quo_o (quo_z)
  );

  // Control delay line matching the divider and back-end stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DlDepth; i++) begin
        dl_q[i] <= '0;
      end
    end else begin
      dl_q[0] <= front_ctrl;
      for (int i = 1; i < DlDepth; i++) begin
        dl_q[i] <= dl_q[i-1];
      end
    end
  end

  assign out_ok = (dl_q[DlDepth-2].status == StOk);

  msc_post u_post_x (
    .clk_i    (clk_i),
    .quo_i    (quo_x),
    .add_i    ($signed({xy_trims_q[7:0], 3'b000})),
    .off_i    ($signed(user_offsets_q[15:0])),
    .scale_i  (user_scales_q[15:0]),
    .cal_en_i (user_cal_en_q),
    .ok_i     (out_ok),
    .field_o  (field_x_o)
  );

  msc_post u_post_y (
    .clk_i    (clk_i),
    .quo_i    (quo_y),
    .add_i    ($signed({xy_trims_q[15:8], 3'b000})),
    .off_i    ($signed(user_offsets_q[31:16])),
    .scale_i  (user_scales_q[31:16]),
    .cal_en_i (user_cal_en_q),
    .ok_i     (out_ok),
    .field_o  (field_y_o)
  );

  msc_post u_post_z (
    .clk_i    (clk_i),
    .quo_i    (quo_z),
    .add_i    (11'sd0),
    .off_i    ($signed(user_offsets_q[47:32])),
    .scale_i  (user_scales_q[47:32]),
    .cal_en_i (user_cal_en_q),
    .ok_i     (out_ok),
    .field_o  (field_z_o)
  );

  assign done_o   = dl_q[DlDepth-1].valid;
  assign status_o = dl_q[DlDepth-1].status;

  // Fixed latency and fault handling
  `MSC_ASSERT_IMP(a_latency, clk_i, rst_ni, start_i, ##Lat done_o)
  `MSC_ASSERT_IMP(a_ovf_path, clk_i, rst_ni, start_i && hall_word_i[0], ##Lat (done_o && status_o == StOverflow))
  `MSC_ASSERT_IMP(a_zero_hall, clk_i, rst_ni, start_i && !hall_word_i[0] && hall_word_i[15:2] == 14'd0, ##Lat (done_o && status_o == StDivZero))
  `MSC_ASSERT_IMP(a_fault_zero, clk_i, rst_ni, done_o && status_o != StOk, field_x_o == 16'sd0 && field_y_o == 16'sd0 && field_z_o == 16'sd0)

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for magnetometer_sample_compensation_core.
// Depends on msc_pkg and the core RTL; directed table then randomized phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import msc_pkg::*;

  localparam int unsigned LatencyCycles = 28;
  localparam int unsigned StallLimit    = 1000;
  localparam int unsigned PhaseItems    = 200;
  localparam logic [2:0]  CfgUnused     = 3'd7;

  typedef struct {
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] fz;
    status_e            st;
  } field_t;

  typedef struct {
    logic [15:0] xw;
    logic [15:0] yw;
    logic [15:0] zw;
    logic [15:0] hw;
    bit          typed;
    field_t      res;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [15:0]        x_word_i = '0;
  logic [15:0]        y_word_i = '0;
  logic [15:0]        z_word_i = '0;
  logic [15:0]        hall_word_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [47:0]        cfg_data_i = '0;
  logic               done_o;
  logic signed [15:0] field_x_o;
  logic signed [15:0] field_y_o;
  logic signed [15:0] field_z_o;
  logic [1:0]         status_o;

  // Shadow of the block's configuration
  logic [47:0] xy_trims_q;
  logic [31:0] hall_z1_q;
  logic [47:0] z_trims_q;
  logic [47:0] offsets_q;
  logic [47:0] scales_q;
  logic        cal_en_q;

  field_t      pending_fields[$];
  int unsigned mismatches = 0;
  int unsigned idle_pct = 0;
  bit          row_typed = 1'b0;
  field_t      row_res;

  magnetometer_sample_compensation_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint round_div(longint n, longint d);
    longint unsigned mn, md, q;
    bit neg;
    neg = (n < 0) ^ (d < 0);
    mn  = (n < 0) ? -n : n;
    md  = (d < 0) ? -d : d;
    q   = (mn + md / 2) / md;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint trim_xy(longint raw, longint t1, longint t2, longint h,
                                     longint xyz1, longint xy1, longint xy2);
    longint e, a;
    e = xyz1 - h;
    a = xy2 * (e * e) + xy1 * e * h + 256 * h * h;
    return clamp16(round_div(raw * (t2 + 160) * a, h * h * 8192) + 8 * t1);
  endfunction

  function automatic longint user_adjust(longint v, int k);
    longint off, sc;
    off = longint'($signed(offsets_q[16*k +: 16]));
    sc  = longint'(scales_q[16*k +: 16]);
    return clamp16(round_div((v - off) * sc, 16384));
  endfunction

  // Expected compensated field for one frame under the current configuration
  function automatic field_t compensate(logic [15:0] xw, logic [15:0] yw,
                                        logic [15:0] zw, logic [15:0] hw);
    field_t r;
    longint rx, ry, rz, h, z1, xyz1, z2, z3, z4, d, n, fx, fy, fz;
    rx   = longint'($signed(xw[15:3]));
    ry   = longint'($signed(yw[15:3]));
    rz   = longint'($signed(zw[15:1]));
    h    = longint'(hw[15:2]);
    z1   = longint'(hall_z1_q[15:0]);
    xyz1 = longint'(hall_z1_q[31:16]);
    z2   = longint'($signed(z_trims_q[15:0]));
    z3   = longint'($signed(z_trims_q[31:16]));
    z4   = longint'($signed(z_trims_q[47:32]));
    fx = 0; fy = 0; fz = 0;
    r.st = StOk;
    d = z2 * 32768 + z1 * h;
    if (hw[0]) begin
      r.st = StOverflow;
    end else if (h == 0 || d == 0) begin
      r.st = StDivZero;
    end else begin
      n  = (rz - z4) * 131072 - z3 * (h - xyz1);
      fz = clamp16(round_div(n * 8192, d));
      fx = trim_xy(rx, longint'($signed(xy_trims_q[7:0])),
                   longint'($signed(xy_trims_q[23:16])), h, xyz1,
                   longint'(xy_trims_q[39:32]), longint'($signed(xy_trims_q[47:40])));
      fy = trim_xy(ry, longint'($signed(xy_trims_q[15:8])),
                   longint'($signed(xy_trims_q[31:24])), h, xyz1,
                   longint'(xy_trims_q[39:32]), longint'($signed(xy_trims_q[47:40])));
      if (cal_en_q) begin
        fx = user_adjust(fx, 0);
        fy = user_adjust(fy, 1);
        fz = user_adjust(fz, 2);
      end
    end
    r.fx = fx[15:0];
    r.fy = fy[15:0];
    r.fz = fz[15:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Monitor: queue predictions on accepted frames, compare results, watchdog
  initial begin
    field_t      want;
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && start_i && !busy_o) begin
        pending_fields.push_back(row_typed ? row_res :
                                 compensate(x_word_i, y_word_i, z_word_i, hall_word_i));
        quiet = 0;
      end else if (!done_o) begin
        quiet++;
      end
      if (done_o) begin
        quiet = 0;
        if (pending_fields.size() == 0) begin
          report_mismatch("unexpected transaction", status_o, -1);
        end else begin
          want = pending_fields.pop_front();
          if (field_x_o !== want.fx) report_mismatch("field_x", field_x_o, want.fx);
          if (field_y_o !== want.fy) report_mismatch("field_y", field_y_o, want.fy);
          if (field_z_o !== want.fz) report_mismatch("field_z", field_z_o, want.fz);
          if (status_o !== want.st) report_mismatch("status", status_o, want.st);
        end
      end
      if (quiet >= StallLimit) begin
        $display("watchdog expired");
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    case (idx)
      CfgXyTrims:   xy_trims_q = val;
      CfgHallZ1:    hall_z1_q  = val[31:0];
      CfgZTrims:    z_trims_q  = val;
      CfgUserOffs:  offsets_q  = val;
      CfgUserScale: scales_q   = val;
      CfgUserCalEn: cal_en_q   = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic write_all(logic [47:0] xy, logic [31:0] hz, logic [47:0] zt,
                           logic [47:0] offs, logic [47:0] sc, logic en);
    write_reg(CfgXyTrims, xy);
    write_reg(CfgHallZ1, {16'h0, hz});
    write_reg(CfgZTrims, zt);
    write_reg(CfgUserOffs, offs);
    write_reg(CfgUserScale, sc);
    write_reg(CfgUserCalEn, {47'h0, en});
  endtask

  // One frame, with random sender idle cycles ahead of it
  task automatic send_frame(row_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i     = 1'b1;
    x_word_i    = r.xw;
    y_word_i    = r.yw;
    z_word_i    = r.zw;
    hall_word_i = r.hw;
    row_typed   = r.typed;
    row_res     = r.res;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_fields.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic row_t random_frame(logic [15:0] xyz1);
    row_t        r;
    int unsigned pick;
    logic [13:0] h;
    r.xw = 16'($urandom);
    r.yw = 16'($urandom);
    r.zw = 16'($urandom);
    r.typed = 1'b0;
    r.res = '{0, 0, 0, StOk};
    pick = $urandom_range(99);
    if (pick < 6) begin
      r.hw = 16'($urandom_range(16'hffff)) | 16'h1;
    end else if (pick < 10) begin
      r.hw = {14'h0, 1'($urandom_range(1)), 1'b0};
    end else begin
      if (pick < 60) h = xyz1[13:0] + 14'($signed(10'($urandom)));
      else h = 14'($urandom);
      if (h == 0) h = 1;
      r.hw = {h, 1'($urandom_range(1)), 1'b0};
    end
    return r;
  endfunction

  // Realistic factory trims, random around typical values
  function automatic logic [47:0] typical_xy();
    return {8'($urandom_range(0, 30)), 8'($urandom_range(0, 255)),
            8'($signed($urandom_range(0, 20)) - 10), 8'($signed($urandom_range(0, 20)) - 10),
            8'($urandom), 8'($urandom)};
  endfunction

  initial begin
    row_t        dir_rows[$];
    row_t        r;
    logic [47:0] xy, zt, offs, sc;
    logic [31:0] hz;
    logic        en;
    xy_trims_q = '0;
    hall_z1_q  = '0;
    z_trims_q  = '0;
    offsets_q  = '0;
    scales_q   = UserScalesReset;
    cal_en_q   = 1'b0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed frames at reset configuration: z divisor is zero
    dir_rows = '{
      '{16'h7fff, 16'h8000, 16'hffff, 16'hfffd, 1'b1, '{0, 0, 0, StOverflow}},
      '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 1'b1, '{0, 0, 0, StOverflow}},
      '{16'h1234, 16'h5678, 16'h9abc, 16'h0000, 1'b1, '{0, 0, 0, StDivZero}},
      '{16'hffff, 16'hffff, 16'hffff, 16'h0002, 1'b1, '{0, 0, 0, StDivZero}},
      '{16'h7ff8, 16'h8000, 16'h7ffe, 16'hfffc, 1'b1, '{0, 0, 0, StDivZero}},
      '{16'h8000, 16'h7ff8, 16'h8000, 16'h0004, 1'b1, '{0, 0, 0, StDivZero}}
    };
    foreach (dir_rows[i]) send_frame(dir_rows[i]);
    drain();

    // Trims chosen so that z1*H + z2*32768 vanishes at H == 1
    write_all(48'h1e_c8_f6_0a_03_fd, {16'd6500, 16'h8000}, {16'hff00, 16'h0123, 16'hffff},
              48'h0, UserScalesReset, 1'b0);
    dir_rows = '{
      '{16'h0000, 16'h0000, 16'h0000, 16'h0004, 1'b1, '{0, 0, 0, StDivZero}},
      '{16'h7ff8, 16'h7ff8, 16'h7ffe, 16'h6590, 1'b0, '{0, 0, 0, StOk}},
      '{16'h8000, 16'h8000, 16'h8000, 16'h6590, 1'b0, '{0, 0, 0, StOk}},
      '{16'hffff, 16'h0007, 16'h0001, 16'hfffc, 1'b0, '{0, 0, 0, StOk}},
      '{16'h0008, 16'hfff8, 16'hfffe, 16'h0008, 1'b0, '{0, 0, 0, StOk}},
      '{16'h7fff, 16'h8000, 16'h7fff, 16'h0006, 1'b0, '{0, 0, 0, StOk}},
      '{16'h5555, 16'haaaa, 16'h5555, 16'haaa8, 1'b0, '{0, 0, 0, StOk}},
      '{16'haaaa, 16'h5555, 16'haaaa, 16'h5556, 1'b0, '{0, 0, 0, StOk}}
    };
    foreach (dir_rows[i]) send_frame(dir_rows[i]);
    drain();
    // Saturating user stage with offsets and scales at their extremes
    write_all(48'h1e_c8_7f_80_7f_80, {16'd6500, 16'd24000}, {16'hff00, 16'h7fff, 16'h8000},
              48'h8000_7fff_8000, 48'hffff_ffff_ffff, 1'b1);
    foreach (dir_rows[i]) if (i > 0) send_frame(dir_rows[i]);
    drain();

    // Randomized phases, each under its own configuration
    for (int p = 0; p < 8; p++) begin
      case (p % 5)
        0: idle_pct = 0;
        1: idle_pct = 54;
        2: idle_pct = 22;
        3: idle_pct = 54;
        default: idle_pct = 0;
      endcase
      xy   = typical_xy();
      hz   = {16'($urandom_range(5000, 8000)), 16'($urandom_range(20000, 30000))};
      zt   = {16'($urandom_range(0, 200)), 16'($urandom_range(0, 1000)),
              16'($urandom_range(500, 1000))};
      offs = {16'($signed($urandom_range(0, 2000)) - 1000),
              16'($signed($urandom_range(0, 2000)) - 1000),
              16'($signed($urandom_range(0, 2000)) - 1000)};
      sc   = {16'($urandom_range(12000, 20000)), 16'($urandom_range(12000, 20000)),
              16'($urandom_range(12000, 20000))};
      en   = p[0];
      case (p)
        2: begin
          xy = '0; zt = '0; offs = '0; sc = '0;
          hz = {16'h0, 16'($urandom_range(1, 65535))};
        end
        3: begin
          xy = '1; hz = '1; zt = '1; offs = '1; sc = '1;
        end
        4, 6: begin
          xy = 48'({$urandom, $urandom}); hz = $urandom; zt = 48'({$urandom, $urandom});
          offs = 48'({$urandom, $urandom}); sc = 48'({$urandom, $urandom});
        end
        default: ;
      endcase
      write_all(xy, hz, zt, offs, sc, en);
      // Writes to an index past the register list must be ignored
      if (p == 4) write_reg(CfgUnused, 48'({$urandom, $urandom}));
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 1 && i == PhaseItems / 2) drain();
        r = random_frame(hall_z1_q[31:16]);
        send_frame(r);
      end
      drain();
    end

    repeat (LatencyCycles + 10) @(posedge clk_i);
    if (mismatches == 0 && pending_fields.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/msc_pkg.sv
src/msc_div.sv
src/msc_front.sv
src/msc_post.sv
src/magnetometer_sample_compensation_core.sv
tb/sv/testbench.sv
